/* sv/mmbd_pkg.sv */
package mmbd_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int TIME_BITS    = 32;
   localparam int MAXP_BITS    = 16;
   localparam int TOTAL_BITS   = MAXP_BITS - 1;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [MAXP_BITS-1:0] MIN_DECIMATE = MAXP_BITS'(4);

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_SAMPLE_COUNT = 1'b0;
   localparam csr_index_type CSR_MAX_POINTS   = 1'b1;

   typedef struct packed {
      logic [TIME_BITS-1:0]          sample_time;
      logic signed [SAMPLE_BITS-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]          out_time;
      logic signed [SAMPLE_BITS-1:0] out_value;
      logic                          last_in_run;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]          pt_time;
      logic signed [SAMPLE_BITS-1:0] pt_value;
   } point_type;

   // one queue entry: the points one input item causes
   typedef struct packed {
      point_type first_pt;
      point_type second_pt;
      logic      two_pts;
   } entry_type;

endpackage

/* sv/min_max_bucket_decimator_top.sv */
// channel | direction | handshake            | beat
// req_    | in        | req_valid/req_stall  | req_data: sample_time, sample_value
// rsp_    | out       | rsp_valid/rsp_stall  | rsp_data: out_time, out_value, last_in_run
// csr_    | in        | csr_we               | csr_index, csr_wdata
//
// One sample per cycle is accepted while req_stall is low; a queued result passes
// through the output register to rsp_, and a closing bucket yields up to two beats.
// The front is limited by the four-entry queue to the output register.
// After any csr_ write, the bucket width divider reruns; a sample that would
// start a data set is stalled until it finishes.
// Synchronous reset clears counters, queue and output valid; the registers
// reset to zero, so samples are dropped until sample_count is written.
module min_max_bucket_decimator_top #(
   parameter int COUNT_BITS = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mmbd_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mmbd_pkg::rsp_type       rsp_data,
   input  logic                    csr_we,
   input  mmbd_pkg::csr_index_type csr_index,
   input  logic [((COUNT_BITS > mmbd_pkg::MAXP_BITS) ? COUNT_BITS
                  : mmbd_pkg::MAXP_BITS)-1:0] csr_wdata
);
   import mmbd_pkg::*;

   localparam int WDATA_BITS = (COUNT_BITS > MAXP_BITS) ? COUNT_BITS : MAXP_BITS;

   logic [COUNT_BITS-1:0] pend_count, pend_width;
   logic [TOTAL_BITS-1:0] pend_total;
   logic                  cfg_busy;
   logic                  q_push, q_pop, q_full, q_empty;
   entry_type             q_data, q_head;

   mmbd_cfg #(.COUNT_BITS(COUNT_BITS), .WDATA_BITS(WDATA_BITS)) u_cfg (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .pend_count, .pend_width, .pend_total, .cfg_busy
   );

   mmbd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .pend_count, .pend_width, .pend_total, .cfg_busy,
      .q_full, .q_push, .q_data
   );

   mmbd_queue u_queue (
      .clock, .reset, .q_push, .q_data, .q_pop, .q_head, .q_full, .q_empty
   );

   mmbd_back u_back (
      .clock, .reset, .q_empty, .q_head, .q_pop, .rsp_valid, .rsp_stall, .rsp_data
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("pop from an empty queue");

   a_cfg_holds_start: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> cfg_busy)
      else $error("divider not busy after a register write");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_in_run) |=> rsp_valid)
      else $error("second point of a bucket did not follow");

endmodule

/* sv/mmbd_cfg.sv */
module mmbd_cfg #(
   parameter int COUNT_BITS = 20,
   parameter int WDATA_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  mmbd_pkg::csr_index_type           csr_index,
   input  logic [WDATA_BITS-1:0]             csr_wdata,
   output logic [COUNT_BITS-1:0]             pend_count,
   output logic [COUNT_BITS-1:0]             pend_width,
   output logic [mmbd_pkg::TOTAL_BITS-1:0]   pend_total,
   output logic                              cfg_busy
);
   import mmbd_pkg::*;

   localparam int STEP_BITS = $clog2(COUNT_BITS + 1);
   localparam int CMP_BITS  = (COUNT_BITS > MAXP_BITS) ? COUNT_BITS : MAXP_BITS;

   logic [COUNT_BITS-1:0] count_ff;
   logic [MAXP_BITS-1:0]  maxp_ff;
   logic                  load_ff;
   logic                  busy_ff, busy_in;
   logic [STEP_BITS-1:0]  steps_ff, steps_in;
   logic [TOTAL_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] quo_ff, quo_in;

   logic [TOTAL_BITS:0]   trial;
   logic [TOTAL_BITS:0]   divisor;
   logic [TOTAL_BITS:0]   diff;
   logic                  fits;
   logic                  decimate;

   assign divisor = {1'b0, maxp_ff[MAXP_BITS-1:1]};
   assign trial   = {rem_ff, quo_ff[COUNT_BITS-1]};
   assign diff    = trial - divisor;
   assign fits    = trial >= divisor;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      steps_in = steps_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (load_ff) begin
         busy_in  = 1'b1;
         steps_in = STEP_BITS'(COUNT_BITS);
         rem_in   = '0;
         quo_in   = count_ff;
      end else if (busy_ff) begin
         steps_in = steps_ff - 1'b1;
         busy_in  = steps_ff != STEP_BITS'(1);
         rem_in   = fits ? diff[TOTAL_BITS-1:0] : trial[TOTAL_BITS-1:0];
         quo_in   = {quo_ff[COUNT_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         maxp_ff  <= '0;
         load_ff  <= 1'b0;
         busy_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         load_ff  <= csr_we;
         busy_ff  <= busy_in;
         steps_ff <= steps_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SAMPLE_COUNT: count_ff <= csr_wdata[COUNT_BITS-1:0];
               CSR_MAX_POINTS:   maxp_ff  <= csr_wdata[MAXP_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign decimate = (CMP_BITS'(count_ff) > CMP_BITS'(maxp_ff)) && (maxp_ff >= MIN_DECIMATE);

   assign pend_count = count_ff;
   assign pend_total = maxp_ff[MAXP_BITS-1:1];
   assign pend_width = decimate ? quo_ff : '0;
   assign cfg_busy   = busy_ff || load_ff;

endmodule

/* sv/mmbd_front.sv */
module mmbd_front #(
   parameter int COUNT_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  mmbd_pkg::req_type                req_data,
   input  logic [COUNT_BITS-1:0]            pend_count,
   input  logic [COUNT_BITS-1:0]            pend_width,
   input  logic [mmbd_pkg::TOTAL_BITS-1:0]  pend_total,
   input  logic                             cfg_busy,
   input  logic                             q_full,
   output logic                             q_push,
   output mmbd_pkg::entry_type              q_data
);
   import mmbd_pkg::*;

   logic [COUNT_BITS-1:0]  idx_ff, idx_in;
   logic [COUNT_BITS-1:0]  set_count_ff, set_count_in;
   logic [COUNT_BITS-1:0]  width_ff, width_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic [TOTAL_BITS-1:0]  bnum_ff, bnum_in;
   logic [COUNT_BITS-1:0]  fill_ff, fill_in;

   logic signed [SAMPLE_BITS-1:0] lo_v_ff, lo_v_in, hi_v_ff, hi_v_in;
   logic [TIME_BITS-1:0]          lo_t_ff, lo_t_in, hi_t_ff, hi_t_in;
   logic [COUNT_BITS-1:0]         lo_p_ff, lo_p_in, hi_p_ff, hi_p_in;

   logic                  start, accept, drop, set_end, close, first;
   logic [COUNT_BITS-1:0] eff_count, eff_width, eff_fill, fill_next;
   logic [TOTAL_BITS-1:0] eff_total, eff_bnum;
   point_type             cur_pt, lo_pt, hi_pt;

   assign start     = idx_ff == '0;
   assign req_stall = q_full || (cfg_busy && start);
   assign accept    = req_valid && !req_stall;
   assign drop      = start && (pend_count == '0);

   assign eff_count = start ? pend_count : set_count_ff;
   assign eff_width = start ? pend_width : width_ff;
   assign eff_total = start ? pend_total : total_ff;
   assign eff_fill  = start ? '0 : fill_ff;
   assign eff_bnum  = start ? '0 : bnum_ff;

   assign set_end   = ({1'b0, idx_ff} + 1'b1) >= {1'b0, eff_count};
   assign first     = eff_fill == '0;
   assign fill_next = eff_fill + 1'b1;

   assign cur_pt = '{pt_time: req_data.sample_time, pt_value: req_data.sample_value};
   assign lo_pt  = '{pt_time: lo_t_in, pt_value: lo_v_in};
   assign hi_pt  = '{pt_time: hi_t_in, pt_value: hi_v_in};

   always_comb begin
      lo_v_in = lo_v_ff;
      lo_t_in = lo_t_ff;
      lo_p_in = lo_p_ff;
      hi_v_in = hi_v_ff;
      hi_t_in = hi_t_ff;
      hi_p_in = hi_p_ff;
      // strict compare: the first extreme in a bucket wins ties
      if (first || (req_data.sample_value < lo_v_ff)) begin
         lo_v_in = req_data.sample_value;
         lo_t_in = req_data.sample_time;
         lo_p_in = idx_ff;
      end
      if (first || (req_data.sample_value > hi_v_ff)) begin
         hi_v_in = req_data.sample_value;
         hi_t_in = req_data.sample_time;
         hi_p_in = idx_ff;
      end
   end

   always_comb begin
      if (({1'b0, eff_bnum} + 1'b1) < {1'b0, eff_total})
         close = fill_next >= eff_width;
      else
         close = set_end;
   end

   always_comb begin
      set_count_in = eff_count;
      width_in     = eff_width;
      total_in     = eff_total;
      bnum_in      = eff_bnum;
      fill_in      = eff_fill;
      idx_in       = set_end ? '0 : idx_ff + 1'b1;
      q_push       = 1'b0;
      q_data       = '{first_pt: cur_pt, second_pt: cur_pt, two_pts: 1'b0};
      if (eff_width == '0) begin
         q_push = 1'b1;
      end else begin
         fill_in = fill_next;
         if (close) begin
            q_push  = 1'b1;
            bnum_in = eff_bnum + 1'b1;
            fill_in = '0;
            if (lo_p_in <= hi_p_in) begin
               q_data = '{first_pt: lo_pt, second_pt: hi_pt, two_pts: lo_p_in != hi_p_in};
            end else begin
               q_data = '{first_pt: hi_pt, second_pt: lo_pt, two_pts: 1'b1};
            end
         end
      end
      if (set_end) begin
         bnum_in = '0;
         fill_in = '0;
      end
      if (drop || !accept) begin
         q_push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         bnum_ff      <= '0;
         fill_ff      <= '0;
         width_ff     <= '0;
         set_count_ff <= '0;
         total_ff     <= '0;
      end else if (accept && !drop) begin
         idx_ff       <= idx_in;
         bnum_ff      <= bnum_in;
         fill_ff      <= fill_in;
         width_ff     <= width_in;
         set_count_ff <= set_count_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !drop && (eff_width != '0)) begin
         lo_v_ff <= lo_v_in;
         lo_t_ff <= lo_t_in;
         lo_p_ff <= lo_p_in;
         hi_v_ff <= hi_v_in;
         hi_t_ff <= hi_t_in;
         hi_p_ff <= hi_p_in;
      end
   end

endmodule

/* sv/mmbd_queue.sv */
module mmbd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_push,
   input  mmbd_pkg::entry_type q_data,
   input  logic                q_pop,
   output mmbd_pkg::entry_type q_head,
   output logic                q_full,
   output logic                q_empty
);
   import mmbd_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign q_full  = count_ff == CNT_BITS'(QUEUE_DEPTH);
   assign q_empty = count_ff == '0;
   assign q_head  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (q_push && !q_pop)
         count_in = count_ff + 1'b1;
      else if (q_pop && !q_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (q_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (q_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) mem_ff[wr_ptr_ff] <= q_data;
   end

endmodule

/* sv/mmbd_back.sv */
module mmbd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  mmbd_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mmbd_pkg::rsp_type   rsp_data
);
   import mmbd_pkg::*;

   logic    valid_ff, valid_in;
   logic    half_ff, half_in;
   rsp_type data_ff, data_in;
   logic    out_free;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      data_in  = data_ff;
      q_pop    = 1'b0;
      if (out_free) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            if (!half_ff) begin
               data_in = '{out_time: q_head.first_pt.pt_time,
                           out_value: q_head.first_pt.pt_value,
                           last_in_run: !q_head.two_pts};
               half_in = q_head.two_pts;
               q_pop   = !q_head.two_pts;
            end else begin
               // second point of the entry, then release it
               data_in = '{out_time: q_head.second_pt.pt_time,
                           out_value: q_head.second_pt.pt_value,
                           last_in_run: 1'b1};
               half_in = 1'b0;
               q_pop   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
